>>> hdl/pil_pkg.sv
// pil_pkg: shared constants and types for the piecewise linear interpolator
// no dependencies; imported by piecewise_linear_interpolator and tb
`timescale 1ns / 1ps
`default_nettype none

package pil_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 5;
  localparam int DATA_W     = 32;
  localparam int STEP_W     = DATA_W + 1;
  localparam int PROD_W     = 2 * STEP_W;

  localparam logic OP_EVAL  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } entry_t;

endpackage

`default_nettype wire

>>> hdl/piecewise_linear_interpolator.sv
// piecewise_linear_interpolator: breakpoint table with bit-serial multiply and divide
// depends on pil_pkg
//
// usage:
//   in channel (in_valid/in_ready): operation selects write or evaluate. a write beat
//   stores (x_value, y_value) in slot point_index and gives no result. an evaluate
//   beat gives one y_result beat on the out channel (out_valid/out_ready).
//   config channel (cfg_valid/cfg_ready, always ready) sets point_count; counts above
//   the table depth act as the full depth. write it only while the block is idle.
// sequence:
//   one beat at a time; a write is stored as it is accepted. an evaluate reads the table
//   one slot per cycle (slot 0, last slot, then a scan from slot 1): an empty table
//   goes straight to the output state, a clamped result follows the slot 0 or last-slot
//   check. an interpolated one scans to its segment (slot found 1..15), then runs the
//   shift-add multiply and the restoring divide, one bit per step, and a fix-up state.
//   the block is ready for the next beat in the cycle the result appears.
// reset clears the control state and the count; table contents are undefined until
// written. when the receiver stalls, the finished result waits in the output
// register and the next beat is taken meanwhile; a later result waits in its
// final state until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_interpolator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                operation,
  input  wire logic [pil_pkg::IDX_W-1:0]           point_index,
  input  wire logic signed [pil_pkg::DATA_W-1:0]   x_value,
  input  wire logic signed [pil_pkg::DATA_W-1:0]   y_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [pil_pkg::DATA_W-1:0]        y_result,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [pil_pkg::CNT_W-1:0]           point_count
);

  import pil_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_LAST  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIX   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam int STEP_CW = $clog2(STEP_W);
  localparam logic [STEP_CW-1:0] LAST_STEP = STEP_CW'(STEP_W - 1);

  logic [2:0]                 state;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           n_clamped;
  logic [IDX_W-1:0]           n_last;
  logic [IDX_W-1:0]           idx;
  logic [IDX_W-1:0]           rd_addr_next;
  logic [STEP_CW-1:0]         step;
  entry_t                     table_mem [MAX_POINTS];
  entry_t                     rd_entry;
  entry_t                     prev;
  logic signed [DATA_W-1:0]   xq;
  logic signed [DATA_W-1:0]   y1;
  logic signed [DATA_W-1:0]   res;
  logic                       neg;
  logic [STEP_W-1:0]          mag;
  logic [STEP_W-1:0]          dx;
  logic [PROD_W-1:0]          prod;

  logic                       in_fire;
  logic                       out_free;
  logic                       found;
  logic signed [STEP_W-1:0]   a_diff;
  logic signed [STEP_W-1:0]   dx_diff;
  logic signed [STEP_W-1:0]   dy_diff;
  logic [STEP_W:0]            hi_sum;
  logic [STEP_W:0]            shifted;
  logic [STEP_W:0]            trial;
  logic                       ge;
  logic [STEP_W-1:0]          rem_new;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign n_clamped = (count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count;
  assign found     = (xq < rd_entry.x) || (idx == n_last);

  // segment terms taken from the previous slot and the slot just read
  assign a_diff  = STEP_W'(xq)         - STEP_W'(prev.x);
  assign dx_diff = STEP_W'(rd_entry.x) - STEP_W'(prev.x);
  assign dy_diff = STEP_W'(rd_entry.y) - STEP_W'(prev.y);

  // shift-add multiply, lsb of the multiplier first
  assign hi_sum = {1'b0, prod[PROD_W-1:STEP_W]} + {1'b0, (prod[0] ? mag : '0)};

  // restoring divide, remainder in the upper half, quotient shifts into the lower
  assign shifted = {prod[PROD_W-1:STEP_W], prod[STEP_W-1]};
  assign trial   = shifted - {1'b0, dx};
  assign ge      = (shifted >= {1'b0, dx});
  assign rem_new = ge ? trial[STEP_W-1:0] : shifted[STEP_W-1:0];

  always_comb begin
    case (state)
      S_IDLE:  rd_addr_next = '0;
      S_FIRST: rd_addr_next = n_last;
      S_LAST:  rd_addr_next = IDX_W'(1);
      S_SCAN:  rd_addr_next = idx + 1'b1;
      default: rd_addr_next = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire && operation == OP_WRITE) begin
      table_mem[point_index] <= '{x: x_value, y: y_value};
    end
    rd_entry <= table_mem[rd_addr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
      step      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        count <= point_count;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire && operation == OP_EVAL) begin
            xq     <= x_value;
            n_last <= IDX_W'(n_clamped - 1'b1);
            if (n_clamped == '0) begin
              res   <= '0;
              state <= S_OUT;
            end else begin
              state <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          prev <= rd_entry;
          if (xq <= rd_entry.x) begin
            res   <= rd_entry.y;
            state <= S_OUT;
          end else begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          if (xq >= rd_entry.x) begin
            res   <= rd_entry.y;
            state <= S_OUT;
          end else begin
            idx   <= IDX_W'(1);
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (found) begin
            prod  <= {{STEP_W{1'b0}}, a_diff};
            dx    <= dx_diff;
            neg   <= dy_diff[STEP_W-1];
            mag   <= dy_diff[STEP_W-1] ? STEP_W'(-dy_diff) : dy_diff;
            y1    <= prev.y;
            step  <= '0;
            state <= S_MUL;
          end else begin
            prev <= rd_entry;
            idx  <= idx + 1'b1;
          end
        end
        S_MUL: begin
          prod <= {hi_sum, prod[STEP_W-1:1]};
          if (step == LAST_STEP) begin
            step  <= '0;
            state <= S_DIV;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DIV: begin
          prod <= {rem_new, prod[STEP_W-2:0], ge};
          if (step == LAST_STEP) begin
            step  <= '0;
            state <= S_FIX;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_FIX: begin
          // quotient never exceeds |dy|, so the low word carries it mod 2^32
          res   <= neg ? y1 - $signed(prod[DATA_W-1:0]) : y1 + $signed(prod[DATA_W-1:0]);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            y_result  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // step counter stays within one pass of the serial loops
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL || state == S_DIV) |-> (step <= LAST_STEP))
    else $error("serial step counter overran");

  // scan never leaves the valid part of the table
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (idx != '0 && idx <= n_last))
    else $error("scan index outside table");

  // remainder stays below the divisor after the divide
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIX) |-> (prod[PROD_W-1:STEP_W] < dx))
    else $error("divide remainder not reduced");

  // the segment width is always positive going into the multiply
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && found) |=> (dx != '0 && !dx[STEP_W-1]))
    else $error("segment width not positive");

endmodule

`default_nettype wire

>>> test/tb.sv
// tb: self-checking bench for piecewise_linear_interpolator (breakpoint load and evaluate)
// depends on pil_pkg and the block; random stimulus with stalls on both channels
`timescale 1ns / 1ps

module tb;
  import pil_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int PHASES        = 15;
  localparam int PHASE_ITEMS   = 115;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 600;

  typedef struct {
    logic signed [DATA_W-1:0] x;
    logic [DATA_W-1:0]        y;
  } query_t;

  class curve_scoreboard;
    logic signed [DATA_W-1:0] bx [MAX_POINTS];
    logic signed [DATA_W-1:0] by [MAX_POINTS];
    logic [CNT_W-1:0]         count_q;
    query_t                   pending[$];
    int                       evals;
    int                       errors;

    function new();
      count_q = '0;
      evals   = 0;
      errors  = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] v);
      count_q = v;
    endfunction

    function logic [DATA_W-1:0] interpolate_at(logic signed [DATA_W-1:0] xq);
      int                n, k;
      longint            xl, x1, x2, y1, y2, dy, res;
      longint unsigned   a, dx, mag, q;
      n = (count_q > MAX_POINTS) ? MAX_POINTS : int'(count_q);
      if (n == 0) return '0;
      xl = xq;
      if (xl <= bx[0]) return by[0];
      if (xl >= bx[n-1]) return by[n-1];
      // first slot above x; the last slot always stops the scan
      k = 1;
      while (k < n - 1 && xl >= bx[k]) k++;
      x1 = bx[k-1];
      x2 = bx[k];
      y1 = by[k-1];
      y2 = by[k];
      a   = xl - x1;
      dx  = x2 - x1;
      dy  = y2 - y1;
      mag = (dy < 0) ? -dy : dy;
      q   = (a * mag) / dx;
      res = (dy < 0) ? y1 - longint'(q) : y1 + longint'(q);
      return res[DATA_W-1:0];
    endfunction

    function void note_beat(logic op, logic [IDX_W-1:0] idx,
                            logic signed [DATA_W-1:0] xv, logic signed [DATA_W-1:0] yv);
      query_t e;
      if (op == OP_WRITE) begin
        bx[idx] = xv;
        by[idx] = yv;
      end else begin
        e.x = xv;
        e.y = interpolate_at(xv);
        pending.push_back(e);
        evals++;
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [DATA_W-1:0] y);
      query_t e;
      if (pending.size() == 0) begin
        report($sformatf("y_result %h with no evaluate outstanding", y));
        return;
      end
      e = pending.pop_front();
      if (y !== e.y) report($sformatf("x %h: y_result %h, expected %h", e.x, y, e.y));
    endtask
  endclass

  logic                      clk;
  logic                      rst         = 1'b1;
  logic                      in_valid    = 1'b0;
  logic                      in_ready;
  logic                      operation   = OP_EVAL;
  logic [IDX_W-1:0]          point_index = '0;
  logic signed [DATA_W-1:0]  x_value     = '0;
  logic signed [DATA_W-1:0]  y_value     = '0;
  logic                      out_valid;
  logic                      out_ready   = 1'b0;
  logic signed [DATA_W-1:0]  y_result;
  logic                      cfg_valid   = 1'b0;
  logic                      cfg_ready;
  logic [CNT_W-1:0]          point_count = '0;

  curve_scoreboard sb;
  int              items_sent = 0;
  int              cycle_count = 0;
  bit              tx_quiet = 1'b0;

  piecewise_linear_interpolator dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .point_index (point_index),
    .x_value     (x_value),
    .y_value     (y_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .y_result    (y_result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .point_count (point_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_beat(operation, point_index, x_value, y_value);
      if (out_valid && out_ready) sb.check_result(y_result);
      if (cfg_valid && cfg_ready) sb.set_count(point_count);
    end
  end

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_y();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 8) return ($urandom_range(0, 1) == 0) ? 32'sh80000000 : 32'sh7fffffff;
    if (r < 45) begin
      v = $urandom_range(0, 262143);
      return v - 131072;
    end
    return $urandom;
  endfunction

  // mostly inside a segment, some on breakpoints, some at the range ends, the rest random
  function automatic logic signed [DATA_W-1:0] pick_query(input int n);
    int     r, k;
    longint lo, hi, xq;
    r = $urandom_range(0, 99);
    if (n >= 2 && r < 55) begin
      k  = $urandom_range(0, n - 2);
      lo = sb.bx[k];
      hi = sb.bx[k+1];
      xq = (hi > lo) ? lo + longint'($urandom_range(0, 32'(hi - lo - 1))) : lo;
      return xq[DATA_W-1:0];
    end
    if (n >= 1 && r < 72) return sb.bx[$urandom_range(0, n - 1)];
    if (r < 82) begin
      case ($urandom_range(0, 3))
        0: return 32'sh80000000;
        1: return 32'sh7fffffff;
        2: return 32'sh80000001;
        default: return 32'sh7ffffffe;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] xv,
                           input logic signed [DATA_W-1:0] yv);
    int gap;
    gap = pick_gap(tx_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    operation   = op;
    point_index = idx;
    x_value     = xv;
    y_value     = yv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // writes leave no result, so allow the block to finish one before touching it
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_point_count(input logic [CNT_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid   = 1'b1;
    point_count = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // slots 0..n-1, strictly ascending over a random span unless scrambled
  task automatic load_table(input int n, input bit ordered);
    int     k, sh;
    longint span, width, w1, room, base, xk, prev;
    sh    = $urandom_range(4, 32);
    span  = longint'(1) << sh;
    width = span / n;
    w1    = width - 1;
    room  = 64'sd4294967296 - span;
    base  = -64'sd2147483648 + longint'($urandom_range(0, room[31:0]));
    prev  = base;
    for (k = 0; k < n; k++) begin
      if (ordered) xk = base + k * width + longint'($urandom_range(0, w1[31:0]));
      else if (k > 0 && $urandom_range(0, 3) == 0) xk = prev;
      else xk = $urandom;
      prev = xk;
      send_item(OP_WRITE, IDX_W'(k), xk[DATA_W-1:0], pick_y());
    end
  endtask

  // receiver: random stalls, quiet stretches, and long hold-offs that back up the input
  initial begin
    int stall_left;
    int since;
    int next_hold;
    bit quiet;
    stall_left = 0;
    since      = 0;
    next_hold  = 300;
    quiet      = 1'b0;
    forever begin
      @(negedge clk);
      since++;
      if (since % 256 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (!rst && sb.evals >= next_hold) begin
        next_hold  += 900;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) stall_left = pick_gap(1'b0);
      end
    end
  end

  initial begin
    int                       k, ph, n, r, start, iter;
    int                       phase_counts [PHASES];
    logic signed [DATA_W-1:0] probes [7];
    logic signed [DATA_W-1:0] xd, yd;
    phase_counts = '{16, 1, 2, 31, 0, 17, 3, 16, 2, 9, 16, 5, 20, 16, 4};
    probes = '{32'sh80000000, 32'sh7fffffff, 32'shfd000000, 32'shfd000001,
               32'shffffffff, 32'sh7ffffffe, 32'sh80000001};
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // full table with both x extremes and a full-scale falling segment in the middle
    for (k = 0; k < MAX_POINTS; k++) begin
      if (k == 0) xd = 32'sh80000000;
      else if (k == MAX_POINTS - 1) xd = 32'sh7fffffff;
      else xd = (k - 8) * 16777216;
      if (k == 0 || k == 8) yd = 32'sh80000000;
      else if (k == 7 || k == MAX_POINTS - 1) yd = 32'sh7fffffff;
      else yd = pick_y();
      send_item(OP_WRITE, IDX_W'(k), xd, yd);
    end
    // empty table gives zero
    send_item(OP_EVAL, IDX_W'(MAX_POINTS - 1), 32'sh00012345, 32'shffffffff);
    set_point_count(CNT_W'(MAX_POINTS));
    for (k = 0; k < 7; k++) send_item(OP_EVAL, IDX_W'(k), probes[k], pick_y());

    for (ph = 0; ph < PHASES; ph++) begin
      set_point_count(CNT_W'(phase_counts[ph]));
      n = (phase_counts[ph] > MAX_POINTS) ? MAX_POINTS : phase_counts[ph];
      load_table((n == 0) ? 4 : n, $urandom_range(0, 4) != 0);
      start = items_sent;
      iter  = 0;
      while (items_sent - start < PHASE_ITEMS) begin
        if (iter % 40 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
        iter++;
        r = $urandom_range(0, 99);
        if (r < 5) load_table((n == 0) ? 4 : n, $urandom_range(0, 3) != 0);
        else if (r < 8) send_item(OP_WRITE, IDX_W'($urandom_range(0, MAX_POINTS - 1)),
                                  $urandom, pick_y());
        else send_item(OP_EVAL, IDX_W'($urandom_range(0, MAX_POINTS - 1)),
                       pick_query(n), $urandom);
      end
    end

    wait_idle();
    if (sb.errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

>>> sim.f
hdl/pil_pkg.sv
hdl/piecewise_linear_interpolator.sv
test/tb.sv
